// File: rtl/core/sst_pkg.sv
package sst_pkg;

  localparam int UserW  = 31;
  localparam int ProcW  = 31;
  localparam int CountW = 9;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_FREE   = 3'd1;
  localparam logic [2:0] MODE_FINDU  = 3'd2;
  localparam logic [2:0] MODE_FINDP  = 3'd3;
  localparam logic [2:0] MODE_COUNTU = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [CountW-1:0] COUNT_MAX = 9'd511;

  typedef struct packed {
    logic [ProcW-1:0] proc;
    logic [UserW-1:0] user;
  } slot_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_SCAN = 2'b10
  } fsm_e;

endpackage

// File: rtl/core/sst_if.sv
interface sst_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        is_admin;
  logic [30:0] user_number;
  logic [30:0] process_id;
  logic [7:0]  slot_index;
  modport source (output valid, mode, is_admin, user_number, process_id, slot_index,
                  input ready);
  modport sink (input valid, mode, is_admin, user_number, process_id, slot_index,
                output ready);
endinterface

interface sst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] slot_found;
  logic [8:0] match_count;
  logic [8:0] active_total;
  modport source (output valid, status, slot_found, match_count, active_total,
                  input ready);
  modport sink (input valid, status, slot_found, match_count, active_total,
                output ready);
endinterface

// File: rtl/core/sst_cell.sv
module sst_cell
  import sst_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

// File: rtl/core/session_slot_table.sv
// session_slot_table
// Table of session slots (process id, user number). One input item on in_ch
// carries one operation: insert, free, find by user, find by process or count
// by user. Each item gives exactly one result item on out_ch.
// The slots sit in a ring of cells. While an item is at work the ring rotates
// one slot per cycle past the head cell, where the item is compared and the
// slot is rewritten (claim or clear) as it re-enters the tail; only the last
// rotation can stall (see below). After TABLE_SLOTS rotations every slot is
// back in place and the result is loaded into the output register.
// Items do not overlap: in_ch.ready is high only while no item is in the ring,
// so a new item is taken only after the previous one has left the ring.
// Stall: the result register holds a result until out_ch takes it. A new item
// may rotate meanwhile; it pauses on its last rotation until the register
// frees up. Reset (rst_ni low, asynchronous) clears every slot, the active
// count, the high-water slot and reserved_slots at once; no clearing pass is
// needed. cfg_we_i / cfg_wdata_i write reserved_slots; the user must do so
// only while the block is idle, which the block itself does not enforce.
module session_slot_table
  import sst_pkg::*;
#(
  parameter int TABLE_SLOTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sst_in_if.sink      in_ch,
  sst_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);

  localparam int PW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = (PW > 9) ? PW + 1 : 10;
  localparam logic [PW-1:0] LastPos = PW'(TABLE_SLOTS - 1);

  fsm_e fsm_q, fsm_d;
  logic [8:0] reserved_q;

  // latched item
  logic [2:0]       mode_q;
  logic             admin_q;
  logic [UserW-1:0] user_q;
  logic [ProcW-1:0] pid_q;
  logic [7:0]       idx_q;

  // scan progress and running result
  logic [PW-1:0]     pos_q;
  logic              claimed_q, claimed_d;
  logic              freed_q, freed_d;
  logic              hit_q, hit_d;
  logic [PW-1:0]     found_q, found_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  logic [CountW-1:0] active_q;
  logic [PW-1:0]     hw_q;

  logic out_valid_q;
  logic [1:0] out_status_q;
  logic [7:0] out_found_q;
  logic [CountW-1:0] out_cnt_q;

  slot_t ring [TABLE_SLOTS];
  slot_t head, tail_in;
  logic  step, last;

  assign head = ring[0];
  assign last = (pos_q == LastPos);
  // hold the last rotation while the previous result is still waiting
  assign step = (fsm_q == FSM_SCAN) && !(last && out_valid_q && !out_ch.ready);

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    slot_t nxt;
    if (g == TABLE_SLOTS - 1) begin : g_tail
      assign nxt = tail_in;
    end else begin : g_mid
      assign nxt = ring[g+1];
    end
    sst_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (step),
      .slot_i  (nxt),
      .slot_o  (ring[g])
    );
  end

  // head cell evaluation
  logic ins_take, free_take, in_lim, umatch, pmatch, past_start;
  logic [CW-1:0] start_x;

  always_comb begin
    start_x    = admin_q ? '0 : CW'(reserved_q);
    past_start = CW'(pos_q) >= start_x;
    in_lim     = pos_q <= hw_q;
    ins_take   = (mode_q == MODE_INSERT) && !claimed_q && past_start &&
                 (head.proc == '0) && (head.user == '0);
    free_take  = (mode_q == MODE_FREE) && (CW'(pos_q) == CW'(idx_q)) &&
                 (head.proc != '0);
    umatch     = in_lim && (head.user == user_q);
    pmatch     = in_lim && (head.proc == pid_q) && (head.proc != '0);

    tail_in = head;
    if (ins_take) begin
      tail_in.proc = pid_q;
      tail_in.user = user_q;
    end else if (free_take) begin
      tail_in = '0;
    end

    claimed_d = claimed_q || ins_take;
    freed_d   = freed_q || free_take;
    hit_d     = hit_q;
    found_d   = found_q;
    cnt_d     = cnt_q;
    if (ins_take) begin
      found_d = pos_q;
    end
    if (!hit_q && (((mode_q == MODE_FINDU) && umatch) ||
                   ((mode_q == MODE_FINDP) && pmatch))) begin
      hit_d   = 1'b1;
      found_d = pos_q;
    end
    if ((mode_q == MODE_COUNTU) && umatch) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // final result
  logic [1:0]        res_status;
  logic [7:0]        res_found;
  logic [CountW-1:0] res_cnt, active_d;

  always_comb begin
    res_status = ST_MISS;
    res_found  = '0;
    res_cnt    = '0;
    active_d   = active_q;
    case (mode_q)
      MODE_INSERT: begin
        if (claimed_d) begin
          res_status = ST_OK;
          res_found  = 8'(found_d);
          if (active_q < COUNT_MAX) active_d = active_q + 1'b1;
        end
      end
      MODE_FREE: begin
        if (freed_d) begin
          res_status = ST_OK;
          if (active_q != '0) active_d = active_q - 1'b1;
        end else begin
          res_status = ST_IGNORED;
        end
      end
      MODE_FINDU, MODE_FINDP: begin
        if (hit_d) begin
          res_status = ST_OK;
          res_found  = 8'(found_d);
        end
      end
      MODE_COUNTU: begin
        res_status = ST_OK;
        res_cnt    = cnt_d;
      end
      default: ;
    endcase
  end

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      FSM_IDLE: if (in_ch.valid) fsm_d = FSM_SCAN;
      FSM_SCAN: if (step && last) fsm_d = FSM_IDLE;
      default:  fsm_d = FSM_IDLE;
    endcase
  end

  assign in_ch.ready = (fsm_q == FSM_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      reserved_q  <= '0;
      active_q    <= '0;
      hw_q        <= '0;
      pos_q       <= '0;
      claimed_q   <= 1'b0;
      freed_q     <= 1'b0;
      hit_q       <= 1'b0;
      found_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      if (cfg_we_i) reserved_q <= cfg_wdata_i;
      if (in_ch.valid && in_ch.ready) begin
        pos_q     <= '0;
        claimed_q <= 1'b0;
        freed_q   <= 1'b0;
        hit_q     <= 1'b0;
        found_q   <= '0;
        cnt_q     <= '0;
      end else if (step) begin
        pos_q     <= pos_q + 1'b1;
        claimed_q <= claimed_d;
        freed_q   <= freed_d;
        hit_q     <= hit_d;
        found_q   <= found_d;
        cnt_q     <= cnt_d;
      end
      if (step && ins_take && (hw_q < pos_q)) hw_q <= pos_q;
      if (step && last) begin
        active_q    <= active_d;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_q  <= in_ch.mode;
      admin_q <= in_ch.is_admin;
      user_q  <= in_ch.user_number;
      pid_q   <= in_ch.process_id;
      idx_q   <= in_ch.slot_index;
    end
    if (step && last) begin
      out_status_q <= res_status;
      out_found_q  <= res_found;
      out_cnt_q    <= res_cnt;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.status       = out_status_q;
  assign out_ch.slot_found   = out_found_q;
  assign out_ch.match_count  = out_cnt_q;
  assign out_ch.active_total = active_q;

endmodule

// File: rtl/core/sst_checker.sv
module sst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] slot_found,
  input logic [8:0] match_count
);

  // one item at a time in the ring
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // a new result never rises in the cycle right after acceptance
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !(out_valid && !$past(out_valid)))
    else $error("result too early");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status != 2'd3)
    else $error("bad status");

  a_ignored_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == 2'd2 |-> slot_found == 8'd0 && match_count == 9'd0)
    else $error("ignored free carries data");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_found))
    else $error("stalled result changed");

endmodule

bind session_slot_table sst_checker u_sst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .slot_found  (out_ch.slot_found),
  .match_count (out_ch.match_count)
);

// File: bench/sst_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side copies are not needed: the RTL interfaces are reused.
// This file holds the pending-item and reply records shared by the bench.
package sst_tb_pkg;
  import sst_pkg::*;

  typedef struct packed {
    logic [2:0]  mode;
    logic        is_admin;
    logic [30:0] user_number;
    logic [30:0] process_id;
    logic [7:0]  slot_index;
  } op_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot_found;
    logic [8:0] match_count;
    logic [8:0] active_total;
  } reply_t;
endpackage

// File: bench/session_slot_table_tb.sv
`timescale 1ns / 1ps
module session_slot_table_tb;
  import sst_pkg::*;
  import sst_tb_pkg::*;

  localparam int Slots = 256;
  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;

  sst_in_if in_ch ();
  sst_out_if out_ch ();

  session_slot_table #(.TABLE_SLOTS(Slots)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the slot table, kept in step with accepted items.
  logic [30:0] shadow_proc [Slots];
  logic [30:0] shadow_user [Slots];
  logic [8:0]  shadow_active;
  logic [7:0]  shadow_high;
  logic [8:0]  shadow_reserved;

  op_t    pending_ops [$];
  reply_t replies_due [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  int  long_hold = 0;
  bit  sending = 1'b0;
  // input item taken at the last rising edge
  bit  in_fire = 1'b0;

  function automatic reply_t table_apply(op_t op);
    reply_t r;
    int lim;
    r = '0;
    r.status = ST_MISS;
    lim = shadow_high;
    case (op.mode)
      MODE_INSERT: begin
        for (int i = op.is_admin ? 0 : shadow_reserved; i < Slots; i++) begin
          if (shadow_proc[i] == '0 && shadow_user[i] == '0) begin
            shadow_proc[i] = op.process_id;
            shadow_user[i] = op.user_number;
            if (shadow_active != COUNT_MAX) shadow_active++;
            if (shadow_high < i) shadow_high = i[7:0];
            r.status = ST_OK;
            r.slot_found = i[7:0];
            break;
          end
        end
      end
      MODE_FREE: begin
        if (shadow_proc[op.slot_index] != '0) begin
          shadow_proc[op.slot_index] = '0;
          shadow_user[op.slot_index] = '0;
          if (shadow_active != '0) shadow_active--;
          r.status = ST_OK;
        end else begin
          r.status = ST_IGNORED;
        end
      end
      MODE_FINDU: begin
        for (int i = 0; i <= lim; i++) begin
          if (shadow_user[i] == op.user_number) begin
            r.status = ST_OK;
            r.slot_found = i[7:0];
            break;
          end
        end
      end
      MODE_FINDP: begin
        for (int i = 0; i <= lim; i++) begin
          if (shadow_proc[i] == op.process_id && op.process_id != '0) begin
            r.status = ST_OK;
            r.slot_found = i[7:0];
            break;
          end
        end
      end
      MODE_COUNTU: begin
        for (int i = 0; i <= lim; i++) begin
          if (shadow_user[i] == op.user_number) r.match_count++;
        end
        r.status = ST_OK;
      end
      default: ;
    endcase
    r.active_total = shadow_active;
    return r;
  endfunction

  // Driver: presents items at the falling edge, with random gaps.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= '0;
      in_ch.is_admin <= 1'b0;
      in_ch.user_number <= '0;
      in_ch.process_id <= '0;
      in_ch.slot_index <= '0;
      gap_left <= 0;
    end else if (in_ch.valid && !in_fire) begin
      // hold the offered item until it is taken
    end else if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (sending && pending_ops.size() > 0) begin
      op_t op;
      op = pending_ops.pop_front();
      in_ch.valid <= 1'b1;
      {in_ch.mode, in_ch.is_admin, in_ch.user_number, in_ch.process_id,
       in_ch.slot_index} <= op;
      gap_left <= $urandom_range(0, 4);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Sink side: random stalls, plus an occasional long hold-off.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (long_hold > 0) begin
      out_ch.ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready) hold_left <= $urandom_range(0, 4);
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        op_t op;
        op = {in_ch.mode, in_ch.is_admin, in_ch.user_number, in_ch.process_id,
              in_ch.slot_index};
        replies_due.push_back(table_apply(op));
      end
      if (out_ch.valid && out_ch.ready) begin
        reply_t got, want;
        got = {out_ch.status, out_ch.slot_found, out_ch.match_count, out_ch.active_total};
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: status %0d/%0d slot %0d/%0d count %0d/%0d active %0d/%0d",
                       want.status, got.status, want.slot_found, got.slot_found,
                       want.match_count, got.match_count, want.active_total,
                       got.active_total);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic op_t make_op(logic [2:0] m, logic adm, logic [30:0] u,
                                  logic [30:0] p, logic [7:0] s);
    op_t op;
    op = {m, adm, u, p, s};
    return op;
  endfunction

  // Random op: mostly insert/free/lookups over a small id pool so hits occur.
  function automatic op_t rand_op();
    op_t op;
    int pick;
    pick = $urandom_range(0, 99);
    op.is_admin = 1'($urandom_range(0, 1));
    op.user_number = ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                                 : 31'($urandom_range(0, 12));
    op.process_id = ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                                : 31'($urandom_range(0, 20));
    op.slot_index = ($urandom_range(0, 1) == 0) ? 8'($urandom())
                                                : 8'($urandom_range(0, 40));
    if (pick < 40) op.mode = MODE_INSERT;
    else if (pick < 65) op.mode = MODE_FREE;
    else if (pick < 78) op.mode = MODE_FINDU;
    else if (pick < 88) op.mode = MODE_FINDP;
    else if (pick < 97) op.mode = MODE_COUNTU;
    else op.mode = 3'($urandom_range(5, 7));
    return op;
  endfunction

  task automatic drain_and_wait();
    wait (pending_ops.size() == 0 && !in_ch.valid);
    wait (replies_due.size() == 0);
    repeat (Slots + 20) @(posedge clk_i);
  endtask

  task automatic write_reserved(logic [8:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_reserved = v;
  endtask

  initial begin
    logic [8:0] settings [5];
    for (int i = 0; i < Slots; i++) begin
      shadow_proc[i] = '0;
      shadow_user[i] = '0;
    end
    shadow_active = '0;
    shadow_high = '0;
    shadow_reserved = '0;
    settings = '{9'd0, 9'd256, 9'd255, 9'd3, 9'd17};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: edges of every field, every mode, zero records, unknown modes.
    write_reserved(9'd2);
    pending_ops.push_back(make_op(MODE_INSERT, 1'b0, 31'h7fffffff, 31'h7fffffff, 8'd0));
    pending_ops.push_back(make_op(MODE_INSERT, 1'b1, 31'd5, 31'd9, 8'd0));
    pending_ops.push_back(make_op(MODE_INSERT, 1'b1, 31'd0, 31'd0, 8'd0));
    pending_ops.push_back(make_op(MODE_INSERT, 1'b1, 31'd5, 31'd0, 8'd0));
    pending_ops.push_back(make_op(MODE_FINDU, 1'b0, 31'd0, 31'd0, 8'd0));
    pending_ops.push_back(make_op(MODE_FINDU, 1'b0, 31'h7fffffff, 31'd0, 8'd0));
    pending_ops.push_back(make_op(MODE_FINDP, 1'b0, 31'd0, 31'd0, 8'd0));
    pending_ops.push_back(make_op(MODE_FINDP, 1'b0, 31'd0, 31'h7fffffff, 8'd0));
    pending_ops.push_back(make_op(MODE_FINDP, 1'b0, 31'd0, 31'd123, 8'd0));
    pending_ops.push_back(make_op(MODE_COUNTU, 1'b0, 31'd5, 31'd0, 8'd0));
    pending_ops.push_back(make_op(MODE_COUNTU, 1'b0, 31'd0, 31'd0, 8'd0));
    pending_ops.push_back(make_op(MODE_FREE, 1'b0, 31'd0, 31'd0, 8'd255));
    pending_ops.push_back(make_op(MODE_FREE, 1'b0, 31'd0, 31'd0, 8'd1));
    pending_ops.push_back(make_op(MODE_FREE, 1'b0, 31'd0, 31'd0, 8'd0));
    pending_ops.push_back(make_op(MODE_FREE, 1'b0, 31'd0, 31'd0, 8'd2));
    pending_ops.push_back(make_op(3'd5, 1'b1, 31'd5, 31'd9, 8'd0));
    pending_ops.push_back(make_op(3'd7, 1'b0, 31'd0, 31'd0, 8'd0));
    sending = 1'b1;
    drain_and_wait();

    // Random phases across reserved-slot settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      sending = 1'b0;
      write_reserved(settings[ph]);
      for (int n = 0; n < 265; n++) pending_ops.push_back(rand_op());
      if (ph == 1) begin
        // Fill the table with admin inserts, overflow it, then free every slot.
        for (int n = 0; n < Slots + 4; n++)
          pending_ops.push_back(make_op(MODE_INSERT, 1'b1, 31'($urandom()),
                                        31'($urandom()), 8'd0));
        for (int n = 0; n < 256; n++)
          pending_ops.push_back(make_op(MODE_FREE, 1'b0, 31'd0, 31'd0, n[7:0]));
      end
      sending = 1'b1;
      if (ph == 2) begin
        // Long sink hold-off while items keep arriving.
        repeat (50) @(posedge clk_i);
        long_hold = 2000;
      end
      drain_and_wait();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
